/* rtl/swr_pkg.sv */
`timescale 1ns / 1ps

package swr_pkg;

   localparam int SEQ_W                = 31;
   localparam int REL_W                = 5;
   localparam int WS_W                 = 5;
   localparam int DIV_CNT_W            = $clog2(SEQ_W);
   localparam int DEFAULT_BUFFER_SLOTS = 16;

   localparam logic [WS_W-1:0] WS_RESET = WS_W'(4);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_DIVIDE  = 5'b00010,
      ST_CHECK   = 5'b00100,
      ST_SCAN    = 5'b01000,
      ST_RESPOND = 5'b10000
   } state_type;

endpackage

/* rtl/swr_if.sv */
`timescale 1ns / 1ps

interface swr_req_if;
   import swr_pkg::*;

   logic             valid;
   logic             ready;
   logic             frame_present;
   logic             checksum_good;
   logic [SEQ_W-1:0] seq_number;

   modport source (output valid, output frame_present, output checksum_good,
                   output seq_number, input ready);
   modport sink   (input valid, input frame_present, input checksum_good,
                   input seq_number, output ready);
endinterface

interface swr_rsp_if;
   import swr_pkg::*;

   logic             valid;
   logic             ready;
   logic             ack_valid;
   logic [SEQ_W-1:0] ack_next_seq;
   logic [REL_W-1:0] release_count;
   logic             stream_done;

   modport source (output valid, output ack_valid, output ack_next_seq,
                   output release_count, output stream_done, input ready);
   modport sink   (input valid, input ack_valid, input ack_next_seq,
                   input release_count, input stream_done, output ready);
endinterface

interface swr_csr_if;
   import swr_pkg::*;

   logic            valid;
   logic            ready;
   logic [WS_W-1:0] window_size;

   modport source (output valid, output window_size, input ready);
   modport sink   (input valid, input window_size, output ready);
endinterface

/* rtl/sliding_window_receiver_core.sv */
`timescale 1ns / 1ps

// Receiver side of a sliding-window protocol. Each req item is one frame header; each
// produces exactly one rsp item carrying the acknowledgement, the number of slots released
// and the end-of-stream flag. The window size register (csr) may be written at any time the
// block holds no item. An accepted frame passes through the check and then the bitmap scan,
// which advances the in-order edge one slot per cycle, before its result is offered; a frame
// that is not accepted goes from the check straight to the response. When BUFFER_SLOTS is not
// a power of two the sequence number is first reduced to a slot, one byte per cycle through
// constant remainder tables. An end-of-stream item goes straight to the response. No new
// item is taken until the previous one has reached the output register, which holds its
// result until the sink takes it.
module sliding_window_receiver_core #(
   parameter int BUFFER_SLOTS = swr_pkg::DEFAULT_BUFFER_SLOTS
) (
   input logic       clock,
   input logic       reset,
   swr_req_if.sink   req_ch,
   swr_rsp_if.source rsp_ch,
   swr_csr_if.sink   csr_ch
);
   import swr_pkg::*;

   localparam int SLOT_W = $clog2(BUFFER_SLOTS);
   localparam int CNT_W  = $clog2(BUFFER_SLOTS + 1);
   localparam int SUM_W  = ((CNT_W > WS_W) ? CNT_W : WS_W) + 1;
   localparam bit IS_POW2 = ((BUFFER_SLOTS & (BUFFER_SLOTS - 1)) == 0);
   localparam int DIG_W  = 8;
   localparam int DIGITS = (SEQ_W + DIG_W - 1) / DIG_W;
   localparam int NUM_W  = DIGITS * DIG_W;

   localparam logic [CNT_W-1:0]     SLOTS_CNT  = CNT_W'(BUFFER_SLOTS);
   localparam logic [CNT_W:0]       SLOTS_TRY  = (CNT_W + 1)'(BUFFER_SLOTS);
   localparam logic [SUM_W-1:0]     SLOTS_SUM  = SUM_W'(BUFFER_SLOTS);
   localparam logic [REL_W-1:0]     SLOTS_REL  = REL_W'(BUFFER_SLOTS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST   = DIV_CNT_W'(DIGITS - 1);

   state_type                state_ff, state_in;
   logic [WS_W-1:0]          ws_ff, ws_in;
   logic [CNT_W-1:0]         ioc_ff, ioc_in;
   logic [BUFFER_SLOTS-1:0]  bitmap_ff, bitmap_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DIV_CNT_W-1:0]     cnt_ff, cnt_in;

   logic                     good_ff, good_in;
   logic [SEQ_W-1:0]         seq_ff, seq_in;
   logic [NUM_W-1:0]         div_ff, div_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic [SEQ_W-1:0]         base_ff, base_in;
   logic                     res_ack_ff, res_ack_in;
   logic [SEQ_W-1:0]         res_seq_ff, res_seq_in;
   logic [REL_W-1:0]         res_rel_ff, res_rel_in;
   logic                     res_done_ff, res_done_in;
   logic                     out_ack_ff, out_ack_in;
   logic [SEQ_W-1:0]         out_seq_ff, out_seq_in;
   logic [REL_W-1:0]         out_rel_ff, out_rel_in;
   logic                     out_done_ff, out_done_in;

   logic [CNT_W-1:0]         hi_tbl [BUFFER_SLOTS];
   logic [CNT_W-1:0]         lo_tbl [1 << DIG_W];

   logic [SUM_W-1:0]         win_sum;
   logic [CNT_W-1:0]         window_end;
   logic [DIG_W-1:0]         digit;
   logic [CNT_W:0]           part_sum;
   logic                     edge_hit;
   logic                     req_take;

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ack_valid     = out_ack_ff;
   assign rsp_ch.ack_next_seq  = out_seq_ff;
   assign rsp_ch.release_count = out_rel_ff;
   assign rsp_ch.stream_done   = out_done_ff;

   always_comb begin
      for (int i = 0; i < BUFFER_SLOTS; i++) begin
         hi_tbl[i] = CNT_W'((i << DIG_W) % BUFFER_SLOTS);
      end
      for (int i = 0; i < (1 << DIG_W); i++) begin
         lo_tbl[i] = CNT_W'(i % BUFFER_SLOTS);
      end
   end

   assign req_take   = req_ch.valid && (state_ff == ST_IDLE);
   assign win_sum    = SUM_W'(ioc_ff) + SUM_W'(ws_ff);
   assign window_end = (win_sum > SLOTS_SUM) ? SLOTS_CNT : win_sum[CNT_W-1:0];
   assign digit      = div_ff[NUM_W-1 -: DIG_W];
   assign part_sum   = {1'b0, hi_tbl[rem_ff[SLOT_W-1:0]]} + {1'b0, lo_tbl[digit]};
   assign edge_hit   = (ioc_ff < SLOTS_CNT) && bitmap_ff[ioc_ff[SLOT_W-1:0]];

   always_comb begin
      state_in     = state_ff;
      ws_in        = (csr_ch.valid) ? csr_ch.window_size : ws_ff;
      ioc_in       = ioc_ff;
      bitmap_in    = bitmap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      cnt_in       = cnt_ff;
      good_in      = good_ff;
      seq_in       = seq_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      base_in      = base_ff;
      res_ack_in   = res_ack_ff;
      res_seq_in   = res_seq_ff;
      res_rel_in   = res_rel_ff;
      res_done_in  = res_done_ff;
      out_ack_in   = out_ack_ff;
      out_seq_in   = out_seq_ff;
      out_rel_in   = out_rel_ff;
      out_done_in  = out_done_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               good_in = req_ch.checksum_good;
               seq_in  = req_ch.seq_number;
               div_in  = NUM_W'(req_ch.seq_number);
               rem_in  = '0;
               cnt_in  = '0;
               if (!req_ch.frame_present) begin
                  res_ack_in  = 1'b0;
                  res_seq_in  = '0;
                  res_rel_in  = REL_W'(ioc_ff);
                  res_done_in = 1'b1;
                  bitmap_in   = '0;
                  ioc_in      = '0;
                  state_in    = ST_RESPOND;
               end else if (IS_POW2) begin
                  rem_in   = CNT_W'(req_ch.seq_number[SLOT_W-1:0]);
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (part_sum >= SLOTS_TRY) begin
               rem_in = CNT_W'(part_sum - SLOTS_TRY);
            end else begin
               rem_in = part_sum[CNT_W-1:0];
            end
            div_in = div_ff << DIG_W;
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            base_in = seq_ff - SEQ_W'(rem_ff);
            if (good_ff && (rem_ff >= ioc_ff) && (rem_ff < window_end)) begin
               bitmap_in[rem_ff[SLOT_W-1:0]] = 1'b1;
               state_in = ST_SCAN;
            end else begin
               res_ack_in  = 1'b0;
               res_seq_in  = '0;
               res_rel_in  = '0;
               res_done_in = 1'b0;
               state_in    = ST_RESPOND;
            end
         end
         ST_SCAN: begin
            if (edge_hit) begin
               ioc_in = ioc_ff + CNT_W'(1);
            end else begin
               res_ack_in  = 1'b1;
               res_seq_in  = base_ff + SEQ_W'(ioc_ff);
               res_done_in = 1'b0;
               if (ioc_ff == SLOTS_CNT) begin
                  res_rel_in = SLOTS_REL;
                  bitmap_in  = '0;
                  ioc_in     = '0;
               end else begin
                  res_rel_in = '0;
               end
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_ack_in   = res_ack_ff;
               out_seq_in   = res_seq_ff;
               out_rel_in   = res_rel_ff;
               out_done_in  = res_done_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ws_ff        <= WS_RESET;
         ioc_ff       <= '0;
         bitmap_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         ws_ff        <= ws_in;
         ioc_ff       <= ioc_in;
         bitmap_ff    <= bitmap_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      good_ff     <= good_in;
      seq_ff      <= seq_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      base_ff     <= base_in;
      res_ack_ff  <= res_ack_in;
      res_seq_ff  <= res_seq_in;
      res_rel_ff  <= res_rel_in;
      res_done_ff <= res_done_in;
      out_ack_ff  <= out_ack_in;
      out_seq_ff  <= out_seq_in;
      out_rel_ff  <= out_rel_in;
      out_done_ff <= out_done_in;
   end

`ifndef SYNTH
   a_edge_in_range: assert property (@(posedge clock) disable iff (reset)
      ioc_ff <= SLOTS_CNT)
      else $error("in-order edge beyond buffer");

   a_done_no_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_done_ff |-> !out_ack_ff)
      else $error("end of stream item carries an acknowledgement");

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff != ST_IDLE)
      else $error("sequencer stayed idle after taking an item");

   a_full_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && !edge_hit && ioc_ff == SLOTS_CNT
      |=> ioc_ff == '0 && bitmap_ff == '0)
      else $error("full buffer not released");
`endif

endmodule
